@@ sv/file_uri_path_decoder_top_assert.svh @@
`ifndef FILE_URI_PATH_DECODER_TOP_ASSERT_SVH
`define FILE_URI_PATH_DECODER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FUPD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante.
`define FUPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/fupd_pkg.sv @@
package fupd_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [3:0] PosSlash1 = 4'd6;
  localparam logic [3:0] PosSlash2 = 4'd7;
  localparam logic [3:0] PosBody   = 4'd8;

  localparam logic [7:0] CharSlash   = 8'h2f;
  localparam logic [7:0] CharPercent = 8'h25;

  localparam logic [7:0] LeadText [6] = '{8'h66, 8'h69, 8'h6c, 8'h65, 8'h3a, 8'h2f};

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusNotFile   = 2'd1,
    StatusNonLocal  = 2'd2,
    StatusBadEscape = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EscNone = 2'd0,
    EscHigh = 2'd1,
    EscLow  = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_uri;
  } in_item_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       run_end;
    logic       path_done;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h57);
    end
    return h;
  endfunction

endpackage

@@ sv/file_uri_path_decoder_top.sv @@
// Results are written into the output queue when their item is accepted and leave it in order.
// Throughput: one item per cycle while not stalled; an item giving two results fills two queue slots.
// Results wait in a four-entry queue; input stalls while fewer than two slots are free.
// Reset (asynchronous, active low) clears the decoder state and empties the queue.
module file_uri_path_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fupd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fupd_pkg::out_item_t out_data_o
);
  import fupd_pkg::*;

  `include "file_uri_path_decoder_top_assert.svh"

  logic [3:0] pos_q, pos_d;
  esc_e       esc_q, esc_d;
  logic [3:0] hi_q, hi_d;
  status_e    err_q, err_d;

  out_item_t         fifo_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       last;
  hex_t       hx;
  logic [1:0] ecnt, nres;
  logic [7:0] eb0, eb1;
  logic       body, body_emit;
  logic [7:0] body_byte;
  out_item_t  res0, res1;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign c       = in_data_i.char_in;
  assign last    = in_data_i.end_of_uri;
  assign hx      = hex_decode(c);

  always_comb begin
    pos_d     = pos_q;
    esc_d     = esc_q;
    hi_d      = hi_q;
    err_d     = err_q;
    ecnt      = 2'd0;
    eb0       = 8'h00;
    eb1       = 8'h00;
    body      = 1'b0;
    body_emit = 1'b0;
    body_byte = 8'h00;

    if (err_q == StatusOk) begin
      if (pos_q < PosSlash1) begin
        if (c == LeadText[pos_q[2:0]]) begin
          pos_d = pos_q + 4'd1;
        end else begin
          err_d = StatusNotFile;
        end
      end else if (pos_q == PosSlash1) begin
        if (c == CharSlash) begin
          pos_d = PosSlash2;
        end else begin
          ecnt  = 2'd1;
          eb0   = CharSlash;
          pos_d = PosBody;
          body  = 1'b1;
        end
      end else if (pos_q == PosSlash2) begin
        if (c == CharSlash) begin
          ecnt  = 2'd1;
          eb0   = CharSlash;
          pos_d = PosBody;
        end else begin
          err_d = StatusNonLocal;
        end
      end else begin
        body = 1'b1;
      end
    end

    if (body) begin
      case (esc_q)
        EscNone: begin
          if (c == CharPercent) begin
            esc_d = EscHigh;
          end else begin
            body_emit = 1'b1;
            body_byte = c;
          end
        end
        EscHigh: begin
          if (!hx.ok) begin
            err_d = StatusBadEscape;
            esc_d = EscNone;
          end else begin
            hi_d  = hx.value;
            esc_d = EscLow;
          end
        end
        default: begin
          if (!hx.ok) begin
            err_d = StatusBadEscape;
          end else begin
            body_emit = 1'b1;
            body_byte = {hi_q, hx.value};
          end
          esc_d = EscNone;
        end
      endcase
    end

    if (body_emit) begin
      if (ecnt == 2'd0) begin
        eb0 = body_byte;
      end else begin
        eb1 = body_byte;
      end
      ecnt = ecnt + 2'd1;
    end

    if (last && err_d == StatusOk) begin
      if (pos_d < PosSlash1) begin
        err_d = StatusNotFile;
      end else if (pos_d == PosSlash1) begin
        ecnt = 2'd1;
        eb0  = CharSlash;
      end else if (pos_d == PosSlash2) begin
        err_d = StatusNonLocal;
      end else if (esc_d != EscNone) begin
        err_d = StatusBadEscape;
      end
    end

    nres = (last && ecnt == 2'd0) ? 2'd1 : ecnt;

    res0.path_byte  = eb0;
    res0.byte_valid = (ecnt != 2'd0);
    res0.run_end    = (nres == 2'd1);
    res0.path_done  = last && (nres == 2'd1);
    res0.status     = (last && nres == 2'd1) ? err_d : StatusOk;

    res1.path_byte  = eb1;
    res1.byte_valid = 1'b1;
    res1.run_end    = 1'b1;
    res1.path_done  = last;
    res1.status     = last ? err_d : StatusOk;

    if (last) begin
      pos_d = 4'd0;
      esc_d = EscNone;
      hi_d  = 4'd0;
      err_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      esc_q <= EscNone;
      hi_q  <= 4'd0;
      err_q <= StatusOk;
    end else if (in_acc) begin
      pos_q <= pos_d;
      esc_q <= esc_d;
      hi_q  <= hi_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && nres != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_acc && nres == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(nres);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (in_acc ? CntW'(nres) : CntW'(0)) - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  assign in_stall_o  = (cnt_q > CntW'(FifoDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  `FUPD_ASSERT_IMPLY(a_room_on_accept, in_acc, cnt_q <= CntW'(FifoDepth - 2))
  `FUPD_ASSERT_IMPLY(a_done_is_run_end, out_valid_o && out_data_o.path_done,
                     out_data_o.run_end)
  `FUPD_ASSERT_IMPLY(a_status_only_done, out_valid_o && !out_data_o.path_done,
                     out_data_o.status == StatusOk)
  `FUPD_ASSERT_IMPLY(a_empty_only_done, out_valid_o && !out_data_o.byte_valid,
                     out_data_o.path_done)
  `FUPD_ASSERT_NEXT(a_state_cleared, in_acc && last,
                    pos_q == 4'd0 && esc_q == EscNone && err_q == StatusOk)

endmodule
